@@ src/bftp_pkg.sv @@
`timescale 1ns / 1ps

package bftp_pkg;

   localparam int LOAD_W = 17;
   localparam int SUM_W = LOAD_W + 1;
   localparam int STATUS_W = 2;
   localparam int PIDX_W = 3;
   localparam int CFG_W = 4;

   localparam logic [LOAD_W-1:0] ONE_FIXED = 17'h10000;
   localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd4;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_NOFIT   = 2'd1,
      STATUS_SKIPPED = 2'd2,
      STATUS_CLEARED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic write;
   } bank_cmd_type;

endpackage

@@ src/bftp_load_bank.sv @@
`timescale 1ns / 1ps

module bftp_load_bank #(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bftp_pkg::bank_cmd_type      cmd,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [bftp_pkg::LOAD_W-1:0] wr_data,
   input  logic [IDX_W-1:0]            rd_idx,
   output logic [bftp_pkg::LOAD_W-1:0] rd_data
);
   import bftp_pkg::*;

   logic [LOAD_W-1:0] load_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         load_ff <= '{default: '0};
      end else if (cmd.write) begin
         load_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = load_ff[rd_idx];

endmodule

@@ src/best_fit_task_partitioner_unit.sv @@
// Order: a task is scanned over each active partition in turn in S_SCAN, and its result is
// registered from S_DONE; a clear, a task while stopped, or a task with no active partition
// goes straight from S_IDLE to S_DONE. A stalled result holds the block until it is taken.
// req_stall is high whenever the block is out of S_IDLE, so a new task is taken only after
// the result of the one before it has been registered.
// Reset clears all partition loads and the stop flag and sets active_partitions to 4.
`timescale 1ns / 1ps

module best_fit_task_partitioner_unit #(
   parameter int MAX_PARTITIONS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bftp_pkg::CFG_W-1:0]    csr_active_partitions,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [bftp_pkg::LOAD_W-1:0]   req_utilization,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bftp_pkg::STATUS_W-1:0] rsp_status,
   output logic [bftp_pkg::PIDX_W-1:0]   rsp_partition_index,
   output logic [bftp_pkg::LOAD_W-1:0]   rsp_new_load
);
   import bftp_pkg::*;

   localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

   state_type state_ff, state_in;
   logic [CFG_W-1:0] active_ff, active_in;
   logic stopped_ff, stopped_in;
   logic mode_ff, mode_in;
   logic [LOAD_W-1:0] util_ff, util_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [SUM_W-1:0] best_sum_ff, best_sum_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [PIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [LOAD_W-1:0] rsp_load_ff, rsp_load_in;

   logic accept;
   logic out_free;
   logic last;
   logic better;
   logic found;
   logic [CNT_W-1:0] sat_count;
   logic [SUM_W-1:0] sum;
   logic [LOAD_W-1:0] rd_data;
   bank_cmd_type bank_cmd;

   assign csr_ready = !reset;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sat_count = ({1'b0, active_ff} > (CFG_W + 1)'(MAX_PARTITIONS))
                      ? CNT_W'(MAX_PARTITIONS) : CNT_W'(active_ff);
   assign last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   assign sum = SUM_W'(rd_data) + SUM_W'(util_ff);
   assign better = (sum <= SUM_W'(ONE_FIXED)) && (sum > best_sum_ff);
   assign found = best_sum_ff != '0;

   bftp_load_bank #(
      .DEPTH (MAX_PARTITIONS),
      .IDX_W (IDX_W)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .cmd     (bank_cmd),
      .wr_idx  (best_idx_ff),
      .wr_data (best_sum_ff[LOAD_W-1:0]),
      .rd_idx  (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode || stopped_ff || (sat_count == '0)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      stopped_in = stopped_ff;
      mode_in = mode_ff;
      util_in = util_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      best_idx_in = best_idx_ff;
      best_sum_in = best_sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_load_in = rsp_load_ff;
      bank_cmd = '0;

      if (csr_valid && csr_ready) begin
         active_in = csr_active_partitions;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               util_in = req_utilization;
               count_in = sat_count;
               idx_in = '0;
               best_idx_in = '0;
               best_sum_in = '0;
            end
         end
         S_SCAN: begin
            if (better) begin
               best_sum_in = sum;
               best_idx_in = idx_ff;
            end
            idx_in = idx_ff + IDX_W'(1);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_load_in = '0;
               if (mode_ff) begin
                  bank_cmd.clear = 1'b1;
                  stopped_in = 1'b0;
                  rsp_status_in = STATUS_CLEARED;
               end else if (stopped_ff) begin
                  rsp_status_in = STATUS_SKIPPED;
               end else if (!found) begin
                  stopped_in = 1'b1;
                  rsp_status_in = STATUS_NOFIT;
               end else begin
                  bank_cmd.write = 1'b1;
                  rsp_status_in = STATUS_PLACED;
                  rsp_index_in = PIDX_W'(best_idx_ff);
                  rsp_load_in = best_sum_ff[LOAD_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= ACTIVE_RESET;
         stopped_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         stopped_ff <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      util_ff <= util_in;
      count_ff <= count_in;
      idx_ff <= idx_in;
      best_idx_ff <= best_idx_in;
      best_sum_ff <= best_sum_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff <= rsp_index_in;
      rsp_load_ff <= rsp_load_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_partition_index = rsp_index_ff;
   assign rsp_new_load = rsp_load_ff;

endmodule

@@ src/bftp_checker.sv @@
`timescale 1ns / 1ps

module bftp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bftp_pkg::STATUS_W-1:0] rsp_status,
   input logic [bftp_pkg::PIDX_W-1:0]   rsp_partition_index,
   input logic [bftp_pkg::LOAD_W-1:0]   rsp_new_load
);
   import bftp_pkg::*;

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("A stalled result beat was dropped.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("A new beat was taken while the previous one was at work.");

   a_placed_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_PLACED)
      |-> (rsp_new_load != '0) && (rsp_new_load <= ONE_FIXED))
      else $error("A placed task reports a load outside the valid range.");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_PLACED)
      |-> (rsp_partition_index == '0) && (rsp_new_load == '0))
      else $error("A result that places nothing carries a nonzero index or load.");

endmodule

bind best_fit_task_partitioner_unit bftp_checker u_bftp_checker (.*);
